// ----- rtl/core/tstc_pkg.sv -----
package tstc_pkg;

	// field widths fixed by the poll and event formats
	localparam int COORD_W = 12;
	localparam int COUNT_W = 8;
	localparam int KIND_W  = 2;
	localparam int KEY_W   = 7;
	localparam int GEST_W  = 3;
	localparam int PAGE_W  = 4;
	localparam int TH_W    = 12;
	localparam int POLLS_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// event kinds
	localparam logic [KIND_W-1:0] EVT_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] EVT_PRESS   = 2'd1;
	localparam logic [KIND_W-1:0] EVT_RELEASE = 2'd2;

	// gesture codes
	localparam logic [GEST_W-1:0] GEST_NONE  = 3'd0;
	localparam logic [GEST_W-1:0] GEST_TAP   = 3'd1;
	localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd2;
	localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd3;
	localparam logic [GEST_W-1:0] GEST_UP    = 3'd4;
	localparam logic [GEST_W-1:0] GEST_DOWN  = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_POINT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_POLLS   = 2'd3;

	// configuration reset values
	localparam logic [TH_W-1:0]    RST_SWIPE_THRESHOLD = 12'd30;
	localparam logic [PAGE_W-1:0]  RST_PAGE_COUNT      = 4'd3;
	localparam logic [COORD_W-1:0] RST_SPLIT_POINT     = 12'd120;
	localparam logic [POLLS_W-1:0] RST_RELEASE_POLLS   = 8'd1;

	// touch-count nibble that flags a finger down
	localparam logic [COUNT_W-1:0] TOUCH_NIBBLE = 8'h0f;

	typedef struct packed {
		logic               read_error;
		logic [COUNT_W-1:0] contact_count;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
	} tstc_in_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [KEY_W-1:0]  key_position;
		logic [GEST_W-1:0] gesture;
		logic [PAGE_W-1:0] page;
		logic              last;
	} tstc_out_t;

endpackage

// ----- rtl/core/touch_swipe_tap_classifier.sv -----
// Touch gesture classifier: takes one controller poll per word and returns one or two
// event words per poll (key press/release, gesture report, current page), the final one
// flagged by last. A poll is held in the input register, classified from it, and its
// words are shown from a two-entry result register. Polls that give one word flow at
// one poll per clock; a poll that gives two words (a pending release plus a press or
// a gesture report) holds the result register until both are taken, so its successor
// waits. The result register drains one word per cycle while out_ready is high, which
// sets the rate. Configuration writes take effect from the next classified poll.
module touch_swipe_tap_classifier #(
	parameter int COORD_BITS = 12,
	parameter int MAX_PAGES  = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  tstc_pkg::tstc_in_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output tstc_pkg::tstc_out_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tstc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tstc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tstc_pkg::*;

	localparam int CMP_W = (COORD_BITS > TH_W) ? COORD_BITS : TH_W;
	localparam logic [PAGE_W-1:0] MAX_P = PAGE_W'(MAX_PAGES);

	// configuration registers
	logic [TH_W-1:0]    swipe_threshold_q;
	logic [PAGE_W-1:0]  page_count_q;
	logic [COORD_W-1:0] split_point_q;
	logic [POLLS_W-1:0] release_polls_q;

	// gesture state
	logic                  touch_active_q;
	logic [COORD_BITS-1:0] start_x_q;
	logic [COORD_BITS-1:0] start_y_q;
	logic [COORD_BITS-1:0] recent_x_q;
	logic [COORD_BITS-1:0] recent_y_q;
	logic [KEY_W-1:0]      latched_key_q;
	logic [PAGE_W-1:0]     page_q;
	logic                  pending_q;
	logic [KEY_W-1:0]      release_key_q;
	logic [POLLS_W-1:0]    countdown_q;

	// input register and result register
	logic      valid_s1;
	tstc_in_t  in_s1;
	tstc_out_t res0_q;
	tstc_out_t res1_q;
	logic [1:0] cnt_q;

	logic go;
	logic pop;

	// classification signals
	logic                  err;
	logic                  down;
	logic [COORD_BITS-1:0] x_c;
	logic [COORD_BITS-1:0] y_c;
	logic [COORD_BITS-1:0] sp_c;
	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic [COORD_BITS-1:0] ax;
	logic [COORD_BITS-1:0] ay;
	logic                  horiz;
	logic                  vert;
	logic                  lift;
	logic [PAGE_W-1:0]     eff_pages;
	logic [PAGE_W-1:0]     page_left;
	logic [PAGE_W-1:0]     page_right;
	logic [PAGE_W-1:0]     page_nxt;
	logic [KEY_W-1:0]      quad_key;
	logic [KEY_W-1:0]      vert_key;
	logic [KEY_W-1:0]      press_key;
	logic [POLLS_W-1:0]    countdown_dec;
	logic [POLLS_W-1:0]    polls_eff;
	logic                  rel;
	logic                  pending_left;
	logic                  prs;
	logic                  ext;
	logic                  two_res;
	logic [GEST_W-1:0]     gest;
	tstc_out_t             w_rel;
	tstc_out_t             w_prs;
	tstc_out_t             w_ext;
	tstc_out_t             r0;
	tstc_out_t             r1;

	// handshakes
	assign pop       = (cnt_q != 2'd0) && out_ready;
	assign go        = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready));
	assign in_ready  = !valid_s1 || go;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = res0_q;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_threshold_q <= RST_SWIPE_THRESHOLD;
			page_count_q      <= RST_PAGE_COUNT;
			split_point_q     <= RST_SPLIT_POINT;
			release_polls_q   <= RST_RELEASE_POLLS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SWIPE_THRESHOLD: swipe_threshold_q <= cfg_data[TH_W-1:0];
				CFG_PAGE_COUNT:      page_count_q      <= cfg_data[PAGE_W-1:0];
				CFG_SPLIT_POINT:     split_point_q     <= cfg_data[COORD_W-1:0];
				CFG_RELEASE_POLLS:   release_polls_q   <= cfg_data[POLLS_W-1:0];
				default: ;
			endcase
		end
	end

	// poll fields
	assign err  = in_s1.read_error;
	assign down = (in_s1.contact_count & TOUCH_NIBBLE) != '0;
	assign x_c  = COORD_BITS'(in_s1.touch_x);
	assign y_c  = COORD_BITS'(in_s1.touch_y);
	assign sp_c = COORD_BITS'(split_point_q);

	// travel and its magnitude
	assign dx = $signed({1'b0, recent_x_q}) - $signed({1'b0, start_x_q});
	assign dy = $signed({1'b0, recent_y_q}) - $signed({1'b0, start_y_q});
	assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
	assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

	// gesture decision on lift
	assign lift  = !err && !down && touch_active_q;
	assign horiz = (ax > ay) && (CMP_W'(ax) >= CMP_W'(swipe_threshold_q));
	assign vert  = !horiz && (CMP_W'(ay) >= CMP_W'(swipe_threshold_q));

	always_comb begin
		if (!lift) begin
			gest = GEST_NONE;
		end else if (horiz) begin
			gest = dx[COORD_BITS] ? GEST_LEFT : GEST_RIGHT;
		end else if (vert) begin
			gest = dy[COORD_BITS] ? GEST_UP : GEST_DOWN;
		end else begin
			gest = GEST_TAP;
		end
	end

	// page count clamp and page stepping with wraparound
	always_comb begin
		if (page_count_q == '0) begin
			eff_pages = PAGE_W'(1);
		end else if (page_count_q > MAX_P) begin
			eff_pages = MAX_P;
		end else begin
			eff_pages = page_count_q;
		end
	end

	assign page_left  = (page_q == '0) ? eff_pages - PAGE_W'(1) : page_q - PAGE_W'(1);
	assign page_right = ((5'(page_q) + 5'd1) >= 5'(eff_pages)) ? '0 : page_q + PAGE_W'(1);

	always_comb begin
		if (lift && horiz) begin
			page_nxt = dx[COORD_BITS] ? page_left : page_right;
		end else begin
			page_nxt = page_q;
		end
	end

	// key numbers
	always_comb begin
		if (y_c <= sp_c) begin
			quad_key = KEY_W'({page_q, 2'b00}) + ((x_c <= sp_c) ? KEY_W'(1) : KEY_W'(2));
		end else begin
			quad_key = KEY_W'({page_q, 2'b00}) + ((x_c <= sp_c) ? KEY_W'(4) : KEY_W'(3));
		end
	end

	assign vert_key = KEY_W'({eff_pages, 2'b00}) + KEY_W'({page_q, 1'b0})
		+ (dy[COORD_BITS] ? KEY_W'(1) : KEY_W'(2));
	assign press_key = vert ? vert_key : latched_key_q;

	// release timing runs before the sample is taken
	assign countdown_dec = (countdown_q != '0) ? countdown_q - POLLS_W'(1) : countdown_q;
	assign rel           = pending_q && (countdown_dec == '0);
	assign pending_left  = pending_q && !rel;
	assign polls_eff     = (release_polls_q == '0) ? POLLS_W'(1) : release_polls_q;

	// a tap or vertical swipe presses unless a release is still due
	assign prs     = lift && !horiz && !pending_left;
	assign ext     = !prs && (!rel || (gest != GEST_NONE));
	assign two_res = rel && (prs || ext);

	// result words in delivery order
	always_comb begin
		w_rel = '{event_kind: EVT_RELEASE, key_position: release_key_q,
			gesture: GEST_NONE, page: page_nxt, last: 1'b0};
		w_prs = '{event_kind: EVT_PRESS, key_position: press_key,
			gesture: gest, page: page_nxt, last: 1'b0};
		w_ext = '{event_kind: EVT_NONE, key_position: '0,
			gesture: gest, page: page_nxt, last: 1'b0};
		if (rel) begin
			r0 = w_rel;
		end else if (prs) begin
			r0 = w_prs;
		end else begin
			r0 = w_ext;
		end
		r0.last = !two_res;
		r1      = prs ? w_prs : w_ext;
		r1.last = 1'b1;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (go) begin
			cnt_q <= two_res ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res0_q <= r0;
			res1_q <= r1;
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

	// gesture and release state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_active_q <= 1'b0;
			start_x_q      <= '0;
			start_y_q      <= '0;
			recent_x_q     <= '0;
			recent_y_q     <= '0;
			latched_key_q  <= '0;
			page_q         <= '0;
			pending_q      <= 1'b0;
			release_key_q  <= '0;
			countdown_q    <= '0;
		end else if (go) begin
			if (pending_q) begin
				countdown_q <= countdown_dec;
				pending_q   <= pending_left;
			end
			if (prs) begin
				pending_q     <= 1'b1;
				release_key_q <= press_key;
				countdown_q   <= polls_eff;
			end
			if (!err && down) begin
				if (!touch_active_q) begin
					start_x_q      <= x_c;
					start_y_q      <= y_c;
					touch_active_q <= 1'b1;
					latched_key_q  <= quad_key;
				end
				recent_x_q <= x_c;
				recent_y_q <= y_c;
			end
			if (lift) begin
				touch_active_q <= 1'b0;
			end
			page_q <= page_nxt;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result register overfilled");

	a_pending_count: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> countdown_q != '0)
		else $error("release pending with expired countdown");

	a_release_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == EVT_RELEASE |-> out_data.gesture == GEST_NONE)
		else $error("release word carries a gesture");

	a_none_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == EVT_NONE |-> out_data.key_position == '0)
		else $error("word without key event carries a key");
`endif

endmodule
